[hw/rtl/tfb_pkg.sv]
// Shared types and constants for the transmit FIFO image builder.
// No dependencies; every other file in hw/rtl except tfb_if imports this package.
package tfb_pkg;

	localparam int MAX_PAYLOAD = 116;
	localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

	localparam logic [7:0] HDR_LEN      = 8'd9;
	localparam logic [6:0] PAYLOAD_BASE = 7'd11;
	localparam logic [7:0] FC_HI        = 8'h88;
	localparam logic [7:0] FC_INTRA_PAN = 8'h40;
	localparam logic [7:0] TRIG_ACK     = 8'h05;
	localparam logic [7:0] TRIG_NOACK   = 8'h01;
	localparam logic [15:0] BCAST_ADDR  = 16'hFFFF;

	localparam logic OP_DESC = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	localparam logic [1:0] PT_DATA = 2'd0;
	localparam logic [1:0] PT_CMD  = 2'd1;

	localparam logic [7:0] FT_DATA  = 8'd1;
	localparam logic [7:0] FT_CMD   = 8'd3;
	localparam logic [7:0] FT_OTHER = 8'd0;

	// Descriptor expansion steps
	localparam logic [3:0] ST_HDR_LEN = 4'd0;
	localparam logic [3:0] ST_FRM_LEN = 4'd1;
	localparam logic [3:0] ST_FC_LO   = 4'd2;
	localparam logic [3:0] ST_FC_HI   = 4'd3;
	localparam logic [3:0] ST_SEQ     = 4'd4;
	localparam logic [3:0] ST_PAN_LO  = 4'd5;
	localparam logic [3:0] ST_PAN_HI  = 4'd6;
	localparam logic [3:0] ST_DST_LO  = 4'd7;
	localparam logic [3:0] ST_DST_HI  = 4'd8;
	localparam logic [3:0] ST_SRC_LO  = 4'd9;
	localparam logic [3:0] ST_SRC_HI  = 4'd10;
	localparam logic [3:0] ST_TRIG    = 4'd11;

	// Payload byte expansion steps
	localparam logic [3:0] ST_BYTE      = 4'd0;
	localparam logic [3:0] ST_BYTE_TRIG = 4'd1;

	// One classified item between the front and back parts
	typedef struct packed {
		logic        is_desc;
		logic        ack;       // effective ack of the frame
		logic        fin;       // descriptor: empty payload; byte: last byte
		logic [6:0]  len_addr;  // descriptor: clamped length; byte: FIFO address
		logic [7:0]  fc_lo;
		logic [7:0]  seq;
		logic [15:0] pan;
		logic [15:0] dst;
		logic [7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[hw/rtl/tfb_if.sv]
// Valid/ready channel interfaces for the builder's input and result items.
// No dependencies.
interface tfb_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [1:0]  packet_type;
	logic        ack_request;
	logic        broadcast;
	logic [15:0] dest_pan;
	logic [15:0] dest_address;
	logic [6:0]  payload_length;
	logic [7:0]  payload_byte;

	modport source(output valid, output operation, output packet_type, output ack_request,
		output broadcast, output dest_pan, output dest_address, output payload_length,
		output payload_byte, input ready);
	modport sink(input valid, input operation, input packet_type, input ack_request,
		input broadcast, input dest_pan, input dest_address, input payload_length,
		input payload_byte, output ready);
endinterface

interface tfb_out_if;
	logic       valid;
	logic       ready;
	logic       is_trigger;
	logic [6:0] fifo_address;
	logic [7:0] write_data;
	logic       last;

	modport source(output valid, output is_trigger, output fifo_address, output write_data,
		output last, input ready);
	modport sink(input valid, input is_trigger, input fifo_address, input write_data,
		input last, output ready);
endinterface

[hw/rtl/tfb_queue.sv]
// Small register queue of classified items between front and back.
// Depends on tfb_pkg.
module tfb_queue import tfb_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t status
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push_ok;
	logic          pop_ok;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign push_ok      = push && !status.full;
	assign pop_ok       = pop && !status.empty;
	assign pop_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

[hw/rtl/tfb_front.sv]
// Front part: accepts input items, tracks frame state, classifies items into commands.
// Depends on tfb_pkg and tfb_if.
module tfb_front import tfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tfb_in_if.sink    in_ch,
	input  q_status_t qs,
	output logic      push,
	output cmd_t      push_cmd
);
	logic [7:0] seq_q;
	logic       open_q;
	logic [6:0] bytes_q;
	logic [6:0] exp_q;
	logic       ack_q;

	logic       accept;
	logic       is_desc;
	logic [6:0] len;
	logic       effack;
	logic [7:0] ftype;
	logic [6:0] bw_next;
	logic       done;

	assign in_ch.ready = !qs.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_desc     = (in_ch.operation == OP_DESC);
	assign len         = (in_ch.payload_length > MAX_LEN) ? MAX_LEN : in_ch.payload_length;
	assign effack      = in_ch.ack_request && !in_ch.broadcast;
	assign bw_next     = bytes_q + 7'd1;
	assign done        = (bw_next >= exp_q);
	// drop payload bytes that arrive with no open frame
	assign push        = accept && (is_desc || open_q);

	always_comb begin
		case (in_ch.packet_type)
			PT_DATA: ftype = FT_DATA;
			PT_CMD:  ftype = FT_CMD;
			default: ftype = FT_OTHER;
		endcase
	end

	always_comb begin
		push_cmd = '0;
		push_cmd.is_desc = is_desc;
		if (is_desc) begin
			push_cmd.ack      = effack;
			push_cmd.fin      = (len == 7'd0);
			push_cmd.len_addr = len;
			push_cmd.fc_lo    = ftype | FC_INTRA_PAN | {2'b00, effack, 5'b00000};
			push_cmd.seq      = seq_q;
			push_cmd.pan      = in_ch.dest_pan;
			push_cmd.dst      = in_ch.broadcast ? BCAST_ADDR : in_ch.dest_address;
		end else begin
			push_cmd.ack      = ack_q;
			push_cmd.fin      = done;
			push_cmd.len_addr = PAYLOAD_BASE + bw_next - 7'd1;
			push_cmd.data     = in_ch.payload_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			open_q  <= 1'b0;
			bytes_q <= '0;
			exp_q   <= '0;
			ack_q   <= 1'b0;
		end else if (accept) begin
			if (is_desc) begin
				// a new descriptor abandons any unfinished frame
				seq_q   <= seq_q + 8'd1;
				ack_q   <= effack;
				bytes_q <= '0;
				exp_q   <= len;
				open_q  <= (len != 7'd0);
			end else if (open_q) begin
				bytes_q <= bw_next;
				if (done) begin
					open_q <= 1'b0;
				end
			end
		end
	end
endmodule

[hw/rtl/tfb_back.sv]
// Back part: expands each command into FIFO and trigger writes, one per cycle while the receiver is ready.
// Depends on tfb_pkg and tfb_if.
module tfb_back import tfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] src_addr,
	input  q_status_t   qs,
	output logic        pop,
	input  cmd_t        pop_cmd,
	tfb_out_if.source   out_ch
);
	cmd_t       cur_q;
	logic       busy_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic       out_trig_q;
	logic [6:0] out_addr_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	logic       load_out;
	logic       emit;
	logic [3:0] final_step;
	logic       finishing;
	logic       r_trig;
	logic [6:0] r_addr;
	logic [7:0] r_data;
	logic       r_last;
	logic [7:0] trig_val;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.is_trigger   = out_trig_q;
	assign out_ch.fifo_address = out_addr_q;
	assign out_ch.write_data   = out_data_q;
	assign out_ch.last         = out_last_q;

	assign load_out   = !out_valid_q || out_ch.ready;
	assign emit       = busy_q && load_out;
	assign final_step = cur_q.is_desc ? (cur_q.fin ? ST_TRIG : ST_SRC_HI)
		: (cur_q.fin ? ST_BYTE_TRIG : ST_BYTE);
	assign finishing  = emit && (step_q == final_step);
	assign pop        = !qs.empty && (!busy_q || finishing);
	assign trig_val   = cur_q.ack ? TRIG_ACK : TRIG_NOACK;

	always_comb begin
		r_trig = 1'b0;
		r_addr = 7'(step_q);
		r_data = '0;
		r_last = 1'b0;
		if (cur_q.is_desc) begin
			case (step_q)
				ST_HDR_LEN: r_data = HDR_LEN;
				ST_FRM_LEN: r_data = HDR_LEN + {1'b0, cur_q.len_addr};
				ST_FC_LO:   r_data = cur_q.fc_lo;
				ST_FC_HI:   r_data = FC_HI;
				ST_SEQ:     r_data = cur_q.seq;
				ST_PAN_LO:  r_data = cur_q.pan[7:0];
				ST_PAN_HI:  r_data = cur_q.pan[15:8];
				ST_DST_LO:  r_data = cur_q.dst[7:0];
				ST_DST_HI:  r_data = cur_q.dst[15:8];
				ST_SRC_LO:  r_data = src_addr[7:0];
				ST_SRC_HI: begin
					r_data = src_addr[15:8];
					r_last = cur_q.fin;
				end
				ST_TRIG: begin
					r_trig = 1'b1;
					r_addr = '0;
					r_data = trig_val;
					r_last = 1'b1;
				end
				default: begin
					r_addr = '0;
				end
			endcase
		end else begin
			case (step_q)
				ST_BYTE: begin
					r_addr = cur_q.len_addr;
					r_data = cur_q.data;
					r_last = cur_q.fin;
				end
				default: begin
					r_trig = 1'b1;
					r_addr = '0;
					r_data = trig_val;
					r_last = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_cmd;
		end
		if (emit) begin
			out_trig_q <= r_trig;
			out_addr_q <= r_addr;
			out_data_q <= r_data;
			out_last_q <= r_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (finishing) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 4'd1;
			end
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end
endmodule

[hw/rtl/tx_frame_fifo_builder_top.sv]
// Path: an accepted item goes through the queue, the back end's command register and the output register.
// Throughput: one result per cycle while the receiver is ready; a descriptor gives 11 header writes,
// 12 with the trigger of an empty payload, a payload byte one write, two when it closes the frame.
// Items are accepted every cycle while the QUEUE_DEPTH-entry command queue has room.
// Reset: arst_n clears frame state, queue, expander and the source address register.
// Depends on tfb_pkg, tfb_if, tfb_queue, tfb_front and tfb_back.
module tx_frame_fifo_builder_top import tfb_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	tfb_in_if.sink      in_ch,
	tfb_out_if.source   out_ch,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	// Own short address; the user must have it written only while the block is idle (the block
	// does not enforce this), so the back end reads it directly when it emits the source address bytes.
	logic [15:0] src_addr_q;

	// Commands travel from the front to the back through the queue
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      pop_cmd;
	q_status_t qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
		end else if (cfg_wr_en) begin
			src_addr_q <= cfg_wr_data;
		end
	end

	// Front: accept items, keep sequence number and byte count, drop stray bytes
	tfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.qs       (qs),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Decouple acceptance from the expansion into writes
	tfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (qs)
	);

	// Back: expand each command into header, payload and trigger writes
	tfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_addr (src_addr_q),
		.qs       (qs),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.out_ch   (out_ch)
	);
endmodule

[hw/rtl/tfb_checker.sv]
// Port-level checks on the result channel of the builder, and their bind.
// Depends on tfb_pkg and tx_frame_fifo_builder_top.
module tfb_checker import tfb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_trigger,
	input logic [6:0] fifo_address,
	input logic [7:0] write_data,
	input logic       last
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_data)
			&& $stable(fifo_address) && $stable(is_trigger) && $stable(last))
		else $error("result changed while stalled");

	a_trig_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_trigger |-> last && fifo_address == 7'd0)
		else $error("trigger write not last or at nonzero address");

	a_trig_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_trigger |-> write_data == TRIG_ACK || write_data == TRIG_NOACK)
		else $error("bad trigger value");

	a_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_trigger && fifo_address == 7'd0 |-> write_data == HDR_LEN && !last)
		else $error("bad header length write");
endmodule

bind tx_frame_fifo_builder_top tfb_checker u_tfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.is_trigger   (out_ch.is_trigger),
	.fifo_address (out_ch.fifo_address),
	.write_data   (out_ch.write_data),
	.last         (out_ch.last)
);

[bench/tx_frame_fifo_builder_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for tx_frame_fifo_builder_top: sends frame descriptors and payload bytes,
// predicts every FIFO and trigger write of the builder and checks them in order.
// Depends on tfb_pkg, tfb_if (tfb_in_if, tfb_out_if) and the builder RTL.
module tx_frame_fifo_builder_top_tb;
	import tfb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 32;
	localparam int HOLD_CYCLES    = 400;
	localparam int MAX_REPORTS    = 10;
	localparam int RAND_DESCS     = 248;
	localparam int DESCS_PER_CFG  = 64;

	localparam logic [7:0] FC_ACK     = 8'h20;
	localparam logic [1:0] PT_OTHER   = 2'd2;
	localparam logic [1:0] PT_UNKNOWN = 2'd3;

	// One input item as the sender sees it
	typedef struct packed {
		logic        op;
		logic [1:0]  ptype;
		logic        ack;
		logic        bc;
		logic [15:0] pan;
		logic [15:0] dst;
		logic [6:0]  len;
		logic [7:0]  data;
	} frame_req_t;

	// One write the builder is expected to issue
	typedef struct packed {
		logic       trig;
		logic [6:0] addr;
		logic [7:0] data;
		logic       is_last;
	} fifo_wr_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	tfb_in_if  in_ch();
	tfb_out_if out_ch();

	tx_frame_fifo_builder_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Builder state as predicted by the bench
	logic [15:0] own_addr;
	logic [7:0]  seq_num;
	logic        frame_open;
	logic [6:0]  bytes_sent;
	logic [6:0]  frame_len;
	logic        ack_pend;

	fifo_wr_t fifo_writes[$];   // writes predicted but not yet seen
	int       mismatches;
	int       idle_cycles;
	int       burst_left;
	int       desc_count;

	// Long receiver hold-off: the test bumps hold_reqs, the receiver counts the stall
	int       hold_reqs;
	int       hold_seen;
	int       hold_left;
	logic [15:0] stall_mask;
	logic [3:0]  mask_pos;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Work out the writes that one accepted item causes and advance the model state.
	task automatic predict_writes(input frame_req_t r);
		logic [7:0]  hdr [0:10];
		logic [6:0]  plen;
		logic [7:0]  ftype;
		logic        eff_ack;
		logic [15:0] dst;
		if (r.op == OP_DESC) begin
			plen = (r.len > MAX_LEN) ? MAX_LEN : r.len;
			eff_ack = r.ack & ~r.bc;
			case (r.ptype)
				PT_DATA: ftype = FT_DATA;
				PT_CMD:  ftype = FT_CMD;
				default: ftype = FT_OTHER;
			endcase
			dst = r.bc ? BCAST_ADDR : r.dst;
			hdr[0]  = HDR_LEN;
			hdr[1]  = HDR_LEN + 8'(plen);
			hdr[2]  = ftype | (eff_ack ? FC_ACK : 8'h00) | FC_INTRA_PAN;
			hdr[3]  = FC_HI;
			hdr[4]  = seq_num;
			hdr[5]  = r.pan[7:0];
			hdr[6]  = r.pan[15:8];
			hdr[7]  = dst[7:0];
			hdr[8]  = dst[15:8];
			hdr[9]  = own_addr[7:0];
			hdr[10] = own_addr[15:8];
			for (int i = 0; i < 11; i++)
				fifo_writes.push_back(fifo_wr_t'{1'b0, 7'(i), hdr[i], (i == 10) && (plen == 0)});
			seq_num++;
			ack_pend = eff_ack;
			bytes_sent = '0;
			frame_len = plen;
			frame_open = (plen != 0);
			if (plen == 0)
				fifo_writes.push_back(fifo_wr_t'{1'b1, 7'd0, TRIG_NOACK | (ack_pend ? TRIG_ACK : 8'h00),
					1'b1});
		end else if (frame_open) begin
			// a byte with no open frame falls through and causes nothing
			bytes_sent = bytes_sent + 7'd1;
			fifo_writes.push_back(fifo_wr_t'{1'b0, PAYLOAD_BASE + bytes_sent - 7'd1, r.data,
				bytes_sent >= frame_len});
			if (bytes_sent >= frame_len) begin
				fifo_writes.push_back(fifo_wr_t'{1'b1, 7'd0, ack_pend ? TRIG_ACK : TRIG_NOACK, 1'b1});
				frame_open = 1'b0;
			end
		end
	endtask

	// Sample both handshakes at the edge; predict on input, check on output.
	always @(posedge clk) begin : monitor
		fifo_wr_t seen;
		fifo_wr_t want;
		logic     moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				moved = 1'b1;
				predict_writes(frame_req_t'{in_ch.operation, in_ch.packet_type, in_ch.ack_request,
					in_ch.broadcast, in_ch.dest_pan, in_ch.dest_address, in_ch.payload_length,
					in_ch.payload_byte});
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				seen = fifo_wr_t'{out_ch.is_trigger, out_ch.fifo_address, out_ch.write_data,
					out_ch.last};
				if (fifo_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected write trig=%0b addr=%0d data=%02h last=%0b",
							$realtime, seen.trig, seen.addr, seen.data, seen.is_last);
				end else begin
					want = fifo_writes.pop_front();
					if (seen.trig !== want.trig || seen.addr !== want.addr ||
							seen.data !== want.data || seen.is_last !== want.is_last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: mismatch exp %0b/%0d/%02h/%0b got %0b/%0d/%02h/%0b",
								$realtime, want.trig, want.addr, want.data, want.is_last,
								seen.trig, seen.addr, seen.data, seen.is_last);
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// Receiver: stall on a rotating 16-bit mask, reloaded with a random pattern at each wrap;
	// a hold-off request overrides it, holding ready low while hold_left counts down from HOLD_CYCLES.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= stall_mask[mask_pos];
			mask_pos = mask_pos + 4'd1;
			if (mask_pos == 4'd0) begin
				case ($urandom_range(0, 3))
					0: stall_mask = '1;
					1: stall_mask = 16'($urandom | $urandom);
					2: stall_mask = 16'($urandom) | 16'h0001;
					default: stall_mask = 16'($urandom & $urandom) | 16'h0001;
				endcase
			end
		end
	end

	// Timeout: nothing moved on either side for too long.
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("tx_frame_fifo_builder_top_tb NOT OK");
		$finish;
	end

	function automatic frame_req_t mk_desc(input logic [1:0] ptype, input logic ack,
			input logic bc, input logic [15:0] pan, input logic [15:0] dst, input logic [6:0] len);
		return frame_req_t'{OP_DESC, ptype, ack, bc, pan, dst, len, 8'($urandom)};
	endfunction

	// Descriptor fields of a byte item carry noise; the builder must ignore them.
	function automatic frame_req_t mk_byte(input logic [7:0] b);
		return frame_req_t'{OP_BYTE, 2'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
			16'($urandom), 7'($urandom), b};
	endfunction

	// Offer one item and hold it until accepted; gaps open between bursts.
	task automatic send_item(input frame_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid          <= 1'b1;
		in_ch.operation      <= r.op;
		in_ch.packet_type    <= r.ptype;
		in_ch.ack_request    <= r.ack;
		in_ch.broadcast      <= r.bc;
		in_ch.dest_pan       <= r.pan;
		in_ch.dest_address   <= r.dst;
		in_ch.payload_length <= r.len;
		in_ch.payload_byte   <= r.data;
		do @(posedge clk); while (!in_ch.ready);
		if (r.op == OP_DESC)
			desc_count++;
	endtask

	// Drop valid, wait out every predicted write, then let in-flight ignored items settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (fifo_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the builder idle.
	task automatic write_own_addr(input logic [15:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		own_addr = v;
	endtask

	// Field extremes, every packet type, broadcast vs ack, stray bytes, clamping
	// and abandoning an open frame with a new descriptor.
	task automatic test_directed_frames();
		write_own_addr(16'hFFFF);
		send_item(mk_byte(8'h00));                                   // no frame open: ignored
		send_item(mk_desc(PT_DATA, 1'b1, 1'b0, 16'h0000, 16'h0000, 7'd0));
		send_item(mk_desc(PT_CMD, 1'b1, 1'b1, 16'hFFFF, 16'h1234, 7'd0)); // broadcast drops ack
		send_item(mk_desc(PT_UNKNOWN, 1'b0, 1'b0, 16'hA5C3, 16'h5A3C, 7'd2));
		send_item(mk_byte(8'h00));
		send_item(mk_byte(8'hFF));
		send_item(mk_desc(PT_OTHER, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 7'd1));
		send_item(mk_byte(8'h80));
		drain();
		write_own_addr(16'h0000);
		send_item(mk_desc(PT_DATA, 1'b0, 1'b0, 16'h3C5A, 16'hC3A5, 7'd127)); // clamped length
		send_item(mk_byte(8'h55));
		send_item(mk_desc(PT_CMD, 1'b1, 1'b0, 16'h0001, 16'hFFFE, 7'd3));    // abandons the frame
		send_item(mk_byte(8'hAA));
		send_item(mk_desc(PT_DATA, 1'b1, 1'b1, 16'h8000, 16'h0001, 7'd0));
		send_item(mk_byte(8'h7F));                                   // frame closed: ignored
		send_item(mk_desc(PT_DATA, 1'b1, 1'b0, 16'h1111, 16'h2222, 7'd116));
		send_item(mk_byte(8'h01));
		send_item(mk_desc(PT_OTHER, 1'b0, 1'b0, 16'h7FFF, 16'h8000, 7'd0));
		drain();
	endtask

	// Mostly well-formed short frames with random content, enough descriptors to
	// wrap the sequence number; some frames are cut short and stray bytes slip in.
	task automatic test_random_traffic();
		int         n_bytes;
		int         pick;
		int         phase_descs;
		logic [6:0] len;
		logic [15:0] pan;
		logic [15:0] dst;
		phase_descs = 0;
		desc_count = 0;
		while (desc_count < RAND_DESCS) begin
			if (phase_descs == DESCS_PER_CFG) begin
				drain();
				write_own_addr(($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
				phase_descs = 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 94) begin
				len = 7'd0;
				n_bytes = 0;
			end else if (pick < 98) begin
				len = 7'($urandom_range(1, 4));
				n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
			end else begin
				len = 7'($urandom_range(5, 127));
				n_bytes = $urandom_range(0, 3);
			end
			pan = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
			dst = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
			send_item(mk_desc(2'($urandom), 1'($urandom), $urandom_range(0, 3) == 0, pan, dst, len));
			phase_descs++;
			for (int i = 0; i < n_bytes; i++)
				send_item(mk_byte(8'($urandom)));
			if ($urandom_range(0, 47) == 0)
				send_item(mk_byte(8'($urandom)));
		end
		drain();
	endtask

	// A full overlong frame while the receiver holds off: the command queue fills
	// and the input stalls; the trigger must still follow the 116th byte.
	task automatic test_full_frame_under_pressure();
		write_own_addr(16'($urandom));
		hold_reqs <= hold_reqs + 1;
		send_item(mk_desc(PT_DATA, 1'b1, 1'b0, 16'($urandom), 16'($urandom), 7'd127));
		for (int i = 0; i < MAX_PAYLOAD; i++)
			send_item(mk_byte(8'($urandom)));
		drain();
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		in_ch.valid          = 1'b0;
		in_ch.operation      = OP_DESC;
		in_ch.packet_type    = PT_DATA;
		in_ch.ack_request    = 1'b0;
		in_ch.broadcast      = 1'b0;
		in_ch.dest_pan       = '0;
		in_ch.dest_address   = '0;
		in_ch.payload_length = '0;
		in_ch.payload_byte   = '0;
		own_addr             = '0;
		seq_num              = '0;
		frame_open           = 1'b0;
		bytes_sent           = '0;
		frame_len            = '0;
		ack_pend             = 1'b0;
		mismatches           = 0;
		idle_cycles          = 0;
		burst_left           = 0;
		desc_count           = 0;
		hold_reqs            = 0;
		hold_seen            = 0;
		hold_left            = 0;
		stall_mask           = '1;
		mask_pos             = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_traffic();
		test_full_frame_under_pressure();

		if (mismatches == 0 && fifo_writes.size() == 0)
			$display("tx_frame_fifo_builder_top_tb OK");
		else
			$display("tx_frame_fifo_builder_top_tb NOT OK");
		$finish;
	end

endmodule

[files.f]
hw/rtl/tfb_pkg.sv
hw/rtl/tfb_if.sv
hw/rtl/tfb_queue.sv
hw/rtl/tfb_front.sv
hw/rtl/tfb_back.sv
hw/rtl/tx_frame_fifo_builder_top.sv
hw/rtl/tfb_checker.sv
bench/tx_frame_fifo_builder_top_tb.sv
